>>> hdl/mna_pkg.sv
// ----------------------------------------------------------------------------
// mna_pkg
// Shared constants, codes and types of the MNA stamping engine.
// ----------------------------------------------------------------------------
package mna_pkg;

    // Matrix geometry and fixed-point format
    localparam int MAX_DIM   = 64;
    localparam int FRAC_BITS = 16;
    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * DIM_W;
    localparam int DIV_W     = 2 * FRAC_BITS + 1;
    localparam int DIVC_W    = $clog2(DIV_W + 1);

    // Element kinds
    localparam logic [2:0] K_CLEAR = 3'd0;
    localparam logic [2:0] K_RES   = 3'd1;
    localparam logic [2:0] K_VSRC  = 3'd2;
    localparam logic [2:0] K_IND   = 3'd3;
    localparam logic [2:0] K_ISRC  = 3'd4;
    localparam logic [2:0] K_READ  = 3'd5;

    // Result status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_BAD    = 3'd1;
    localparam logic [2:0] ST_BRANCH = 3'd2;
    localparam logic [2:0] ST_ZERO_R = 3'd3;
    localparam logic [2:0] ST_SAT    = 3'd4;

    // Conductance from the reciprocal unit
    typedef struct packed {
        logic [31:0] g;
        logic        sat;
    } recip_t;

endpackage

>>> hdl/mna_ram.sv
// ----------------------------------------------------------------------------
// mna_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mna_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read through one address
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> hdl/mna_recip.sv
// ----------------------------------------------------------------------------
// mna_recip
// Bit-serial restoring divider: conductance 2^(2*FRAC_BITS) / resistance.
// ----------------------------------------------------------------------------
module mna_recip (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [31:0]         value,
    output logic                done,
    output mna_pkg::recip_t     result
);
    import mna_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVC_W-1:0] cnt_reg, cnt_next;
    logic [32:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]  q_reg, q_next;
    logic [31:0]       mag_reg, mag_next;
    logic              neg_reg, neg_next;

    logic [32:0] trial;
    logic        ge;
    logic [63:0] q_wide;
    logic [31:0] q_clamp;

    // One quotient bit per cycle
    always_comb
    begin
        trial     = {rem_reg[31:0], q_reg[DIV_W-1]};
        ge        = trial >= {1'b0, mag_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            q_next    = {1'b1, {(DIV_W-1){1'b0}}};
            mag_next  = value[31] ? (~value + 32'd1) : value;
            neg_next  = value[31];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (trial - {1'b0, mag_reg}) : trial;
            q_next   = {q_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIVC_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
    end

    // Clamp quotient, apply sign, saturate positive full scale
    always_comb
    begin
        q_wide  = 64'(q_reg);
        q_clamp = (q_wide > 64'h8000_0000) ? 32'h8000_0000 : q_wide[31:0];
        if (neg_reg)
        begin
            result.g   = ~q_clamp + 32'd1;
            result.sat = 1'b0;
        end
        else if (q_clamp == 32'h8000_0000)
        begin
            result.g   = 32'h7FFF_FFFF;
            result.sat = 1'b1;
        end
        else
        begin
            result.g   = q_clamp;
            result.sat = 1'b0;
        end
    end

    assign done = done_reg;

endmodule

>>> hdl/mna_stamp_engine.sv
// ----------------------------------------------------------------------------
// mna_stamp_engine
// Modified nodal analysis matrix and right-hand vector builder.
// ----------------------------------------------------------------------------
// Usage:
//   Drive an element on kind/node_plus/node_minus/value/read_* and raise
//   start; the transfer happens at a rising edge with start high, busy low.
//   One result per item appears on read_data for exactly one cycle and on
//   status until the next, marked by done; the receiver cannot stall it.
//   Matrix and vector live in synchronous RAMs; an add stamp reads in S_STEP
//   and writes in S_MOD through the single RAM port, a set stamp in S_STEP.
//   Bad or rejected items end from idle; a read passes S_RDA and S_RDB; a
//   resistor runs the bit-serial reciprocal, then up to four
//   read-modify-writes; a current source up to two vector adds; an inductor
//   up to four set stamps, a voltage source those plus one vector add. A
//   clear item sweeps all 4096 matrix entries, one a cycle, and the vector.
//   One item is in flight at a time. Reset runs the same sweep with busy
//   high and no result; APB configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module mna_stamp_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [6:0]  node_plus,
    input  logic [6:0]  node_minus,
    input  logic [31:0] value,
    input  logic [5:0]  read_row,
    input  logic [5:0]  read_col,
    input  logic        read_vector,
    output logic        done,
    output logic [31:0] read_data,
    output logic [2:0]  status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mna_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_STEP  = 3'd3;
    localparam logic [2:0] S_MOD   = 3'd4;
    localparam logic [2:0] S_RDA   = 3'd5;
    localparam logic [2:0] S_RDB   = 3'd6;

    localparam logic [2:0]  LAST_SLOT = 3'd4;
    localparam logic [31:0] ONE_FX    = 32'(1) << FRAC_BITS;

    // Configuration registers
    logic [6:0] node_count_reg, branch_count_reg;

    // Control state
    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              clr_item_reg, clr_item_next;
    logic [6:0]        branch_index_reg, branch_index_next;
    logic [2:0]        slot_reg, slot_next;
    logic              sat_reg, sat_next;
    logic              done_reg, done_next;

    // Latched item
    logic [2:0]       kind_reg;
    logic             np_nz_reg, nm_nz_reg;
    logic [DIM_W-1:0] np_idx_reg, nm_idx_reg, row_reg, col_reg;
    logic             rvec_reg;
    logic [31:0]      val_reg, g_reg;
    logic [31:0]      data_reg, data_next;
    logic [2:0]       status_reg, status_next;

    // Memory ports
    logic              mat_we, vec_we;
    logic [ADDR_W-1:0] mat_addr;
    logic [DIM_W-1:0]  vec_addr;
    logic [31:0]       mat_wdata, vec_wdata, mat_rdata, vec_rdata;

    // Reciprocal unit
    logic   div_start, div_done;
    recip_t div_res;

    // Decode
    logic             accept;
    logic             np_ok, nm_ok, node_bad;
    logic [7:0]       br_row, dim;
    logic             br_over, rd_bad;
    logic             op_en, op_vec, op_set, op_neg;
    logic [DIM_W-1:0] op_row, op_col;
    logic [31:0]      base;
    logic [32:0]      delta;
    logic [31:0]      cur, sum_sat, set_val;
    logic [33:0]      sum;
    logic             sum_ovf;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = state_reg != S_IDLE;

    // Check terminals, branch room and read position
    always_comb
    begin
        np_ok    = (node_plus == 7'd0) ||
                   ((node_plus <= node_count_reg) && ({2'b0, node_plus} <= 9'(MAX_DIM)));
        nm_ok    = (node_minus == 7'd0) ||
                   ((node_minus <= node_count_reg) && ({2'b0, node_minus} <= 9'(MAX_DIM)));
        node_bad = !np_ok || !nm_ok;
        br_row   = {1'b0, node_count_reg} + {1'b0, branch_index_reg};
        br_over  = (branch_index_reg >= branch_count_reg) || ({1'b0, br_row} >= 9'(MAX_DIM));
        dim      = {1'b0, node_count_reg} + {1'b0, branch_count_reg};
        rd_bad   = ({2'b0, read_row} >= dim) || ({3'b0, read_row} >= 9'(MAX_DIM)) ||
                   (!read_vector && (({2'b0, read_col} >= dim) ||
                                     ({3'b0, read_col} >= 9'(MAX_DIM))));
    end

    // Decode the stamp of the current slot
    always_comb
    begin
        op_en  = 1'b0;
        op_vec = 1'b0;
        op_set = 1'b0;
        op_neg = 1'b0;
        op_row = nm_idx_reg;
        op_col = nm_idx_reg;
        case (kind_reg)
            K_RES:
            begin
                case (slot_reg)
                    3'd0:
                    begin
                        op_en = nm_nz_reg;
                    end
                    3'd1:
                    begin
                        op_en  = np_nz_reg;
                        op_row = np_idx_reg;
                        op_col = np_idx_reg;
                    end
                    3'd2:
                    begin
                        op_en  = nm_nz_reg && np_nz_reg;
                        op_neg = 1'b1;
                        op_col = np_idx_reg;
                    end
                    3'd3:
                    begin
                        op_en  = nm_nz_reg && np_nz_reg;
                        op_neg = 1'b1;
                        op_row = np_idx_reg;
                    end
                    default:
                    begin
                        op_en = 1'b0;
                    end
                endcase
            end
            K_VSRC, K_IND:
            begin
                op_set = 1'b1;
                case (slot_reg)
                    3'd0:
                    begin
                        op_en  = nm_nz_reg;
                        op_neg = 1'b1;
                        op_row = row_reg;
                    end
                    3'd1:
                    begin
                        op_en  = nm_nz_reg;
                        op_neg = 1'b1;
                        op_col = row_reg;
                    end
                    3'd2:
                    begin
                        op_en  = np_nz_reg;
                        op_row = row_reg;
                        op_col = np_idx_reg;
                    end
                    3'd3:
                    begin
                        op_en  = np_nz_reg;
                        op_row = np_idx_reg;
                        op_col = row_reg;
                    end
                    default:
                    begin
                        op_en  = kind_reg == K_VSRC;
                        op_set = 1'b0;
                        op_vec = 1'b1;
                        op_row = row_reg;
                    end
                endcase
            end
            K_ISRC:
            begin
                op_vec = 1'b1;
                case (slot_reg)
                    3'd0:
                    begin
                        op_en = nm_nz_reg;
                    end
                    3'd1:
                    begin
                        op_en  = np_nz_reg;
                        op_neg = 1'b1;
                        op_row = np_idx_reg;
                    end
                    default:
                    begin
                        op_en = 1'b0;
                    end
                endcase
            end
            default:
            begin
                op_en = 1'b0;
            end
        endcase
    end

    // Saturating add of the stamp to the stored entry
    always_comb
    begin
        base    = (kind_reg == K_RES) ? g_reg : val_reg;
        delta   = op_neg ? -{base[31], base} : {base[31], base};
        cur     = op_vec ? vec_rdata : mat_rdata;
        sum     = {{2{cur[31]}}, cur} + {delta[32], delta};
        sum_ovf = 1'b1;
        if (!sum[33] && (sum[32:31] != 2'b00))
        begin
            sum_sat = 32'h7FFF_FFFF;
        end
        else if (sum[33] && (sum[32:31] != 2'b11))
        begin
            sum_sat = 32'h8000_0000;
        end
        else
        begin
            sum_sat = sum[31:0];
            sum_ovf = 1'b0;
        end
        set_val = op_neg ? (~ONE_FX + 32'd1) : ONE_FX;
    end

    // Drive memory ports
    always_comb
    begin
        mat_we    = 1'b0;
        vec_we    = 1'b0;
        mat_addr  = {op_row, op_col};
        vec_addr  = op_row;
        mat_wdata = op_set ? set_val : sum_sat;
        vec_wdata = sum_sat;
        unique case (state_reg)
            S_CLEAR:
            begin
                mat_we    = 1'b1;
                mat_addr  = clr_cnt_reg;
                mat_wdata = '0;
                vec_we    = clr_cnt_reg[ADDR_W-1:DIM_W] == '0;
                vec_addr  = clr_cnt_reg[DIM_W-1:0];
                vec_wdata = '0;
            end
            S_STEP:
            begin
                mat_we = op_en && op_set;
            end
            S_MOD:
            begin
                mat_we = !op_vec;
                vec_we = op_vec;
            end
            S_RDA, S_RDB:
            begin
                mat_addr = {row_reg, col_reg};
                vec_addr = row_reg;
            end
            default:
            begin
                mat_we = 1'b0;
            end
        endcase
    end

    // Sequence items
    always_comb
    begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        clr_item_next     = clr_item_reg;
        branch_index_next = branch_index_reg;
        slot_next         = slot_reg;
        sat_next          = sat_reg;
        done_next         = 1'b0;
        data_next         = '0;
        status_next       = status_reg;
        div_start         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    slot_next = '0;
                    sat_next  = 1'b0;
                    unique case (kind)
                        K_CLEAR:
                        begin
                            state_next        = S_CLEAR;
                            clr_cnt_next      = '0;
                            clr_item_next     = 1'b1;
                            branch_index_next = '0;
                        end
                        K_RES:
                        begin
                            if (node_bad || (value == '0))
                            begin
                                done_next   = 1'b1;
                                status_next = node_bad ? ST_BAD : ST_ZERO_R;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        K_VSRC, K_IND:
                        begin
                            if (node_bad || br_over)
                            begin
                                done_next   = 1'b1;
                                status_next = node_bad ? ST_BAD : ST_BRANCH;
                            end
                            else
                            begin
                                branch_index_next = branch_index_reg + 7'd1;
                                state_next        = S_STEP;
                            end
                        end
                        K_ISRC:
                        begin
                            if (node_bad)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BAD;
                            end
                            else
                            begin
                                state_next = S_STEP;
                            end
                        end
                        K_READ:
                        begin
                            if (rd_bad)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BAD;
                            end
                            else
                            begin
                                state_next = S_RDA;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_BAD;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    state_next    = S_IDLE;
                    done_next     = clr_item_reg;
                    status_next   = ST_OK;
                    clr_item_next = 1'b0;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    sat_next   = div_res.sat;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (op_en && !op_set)
                begin
                    state_next = S_MOD;
                end
                else if (slot_reg == LAST_SLOT)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = sat_reg ? ST_SAT : ST_OK;
                end
                else
                begin
                    slot_next = slot_reg + 3'd1;
                end
            end
            S_MOD:
            begin
                sat_next = sat_reg || sum_ovf;
                if (slot_reg == LAST_SLOT)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = (sat_reg || sum_ovf) ? ST_SAT : ST_OK;
                end
                else
                begin
                    slot_next  = slot_reg + 3'd1;
                    state_next = S_STEP;
                end
            end
            S_RDA:
            begin
                state_next = S_RDB;
            end
            S_RDB:
            begin
                state_next  = S_IDLE;
                done_next   = 1'b1;
                status_next = ST_OK;
                data_next   = rvec_reg ? vec_rdata : mat_rdata;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state; reset starts the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_cnt_reg      <= '0;
            clr_item_reg     <= 1'b0;
            branch_index_reg <= '0;
            slot_reg         <= '0;
            sat_reg          <= 1'b0;
            done_reg         <= 1'b0;
            node_count_reg   <= '0;
            branch_count_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            clr_item_reg     <= clr_item_next;
            branch_index_reg <= branch_index_next;
            slot_reg         <= slot_next;
            sat_reg          <= sat_next;
            done_reg         <= done_next;
            if (psel && penable && pwrite)
            begin
                if (paddr[2])
                begin
                    branch_count_reg <= pwdata[6:0];
                end
                else
                begin
                    node_count_reg <= pwdata[6:0];
                end
            end
        end
    end

    // Capture item payload and result
    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        status_reg <= status_next;
        if (accept)
        begin
            kind_reg   <= kind;
            np_nz_reg  <= node_plus != 7'd0;
            nm_nz_reg  <= node_minus != 7'd0;
            np_idx_reg <= DIM_W'(node_plus - 7'd1);
            nm_idx_reg <= DIM_W'(node_minus - 7'd1);
            val_reg    <= value;
            rvec_reg   <= read_vector;
            if (kind == K_READ)
            begin
                row_reg <= DIM_W'(read_row);
            end
            else
            begin
                row_reg <= DIM_W'(br_row);
            end
            col_reg <= DIM_W'(read_col);
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            g_reg <= div_res.g;
        end
    end

    mna_recip u_recip (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .value  (value),
        .done   (div_done),
        .result (div_res)
    );

    mna_ram #(
        .WIDTH (32),
        .DEPTH (MAX_DIM * MAX_DIM)
    ) u_mat_ram (
        .clk   (clk),
        .we    (mat_we),
        .addr  (mat_addr),
        .wdata (mat_wdata),
        .rdata (mat_rdata)
    );

    mna_ram #(
        .WIDTH (32),
        .DEPTH (MAX_DIM)
    ) u_vec_ram (
        .clk   (clk),
        .we    (vec_we),
        .addr  (vec_addr),
        .wdata (vec_wdata),
        .rdata (vec_rdata)
    );

    // Outputs
    assign done      = done_reg;
    assign read_data = data_reg;
    assign status    = status_reg;
    assign pready    = 1'b1;
    assign prdata    = paddr[2] ? {25'd0, branch_count_reg} : {25'd0, node_count_reg};

endmodule
